### rtl/core/clsr_pkg.sv
// constants and modular helper functions for the combined congruential generator
package clsr_pkg;

  localparam int unsigned GEN_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = GEN_W + MUL_W;

  localparam logic [GEN_W-1:0] MOD1 = 31'd2147483563;
  localparam logic [GEN_W-1:0] MOD2 = 31'd2147483399;
  localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

  // 2^31 mod MODx, used to fold the high part of a product
  localparam logic [7:0] FOLD1 = 8'd85;
  localparam logic [7:0] FOLD2 = 8'd249;

  localparam logic [GEN_W-1:0] OUT_MAX     = 31'd2147483562;
  localparam logic [GEN_W-1:0] GEN1_RESET  = 31'd1;
  localparam logic [GEN_W-1:0] GEN2_RESET  = 31'd123456789;

  typedef logic [GEN_W-1:0]  gen_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [GEN_W:0]    fold_t;

  // hi * 2^31 + lo  ==  hi * k + lo  (mod 2^31 - k); result below twice the modulus
  function automatic fold_t mod_fold(input prod_t p, input logic [7:0] k);
    logic [MUL_W+7:0] hi_k;
    hi_k = p[PROD_W-1:GEN_W] * k;
    return {1'b0, p[GEN_W-1:0]} + (GEN_W+1)'(hi_k);
  endfunction

  // one conditional subtract finishes the reduction
  function automatic gen_t mod_fix(input fold_t v, input gen_t m);
    fold_t d;
    d = v - {1'b0, m};
    return (v >= {1'b0, m}) ? d[GEN_W-1:0] : v[GEN_W-1:0];
  endfunction

endpackage

### rtl/core/combined_lcg_shuffle_rng.sv
// combined two-generator congruential random source with a shuffle table
//
// usage:
//   input channel (in_valid / in_stall) carries one transaction per request:
//   mode = 0 asks for the next number, mode = 1 reseeds from seed_value
//   (zero counts as one) and then draws. every input transaction gives
//   exactly one output transaction on (out_valid / out_stall, random_value).
// timing:
//   a new request is taken only after the previous one has loaded the
//   result register and the block is back in idle. the chain is slot
//   compute (reciprocal multiply then correction), table read (registered
//   memory) and combine, with both generators advancing alongside
//   through a multiply / fold / reduce pipeline. a reseed first runs
//   TABLE_SIZE + 8 warm-up steps, each the same three-stage modular
//   multiply; the last TABLE_SIZE steps each write one table entry.
// reset: input stalls; generators go to 1 and 123456789, the last output to 0
//   and every table entry reads as zero until written.
// stall: the result waits in the output register; the next transaction is
//   still taken and worked on up to the final combine step, which waits
//   until the output register is free.
module combined_lcg_shuffle_rng
  import clsr_pkg::*;
#(
  parameter int TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [30:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] random_value
);

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 8);
  localparam int QW    = IDX_W + 2;
  localparam int RW    = QW + 1;
  localparam longint unsigned SLOT_DIV_L = 64'd1 + 64'd2147483562 / TABLE_SIZE;
  localparam logic [GEN_W-1:0] SLOT_DIV   = GEN_W'(SLOT_DIV_L);
  // floor(2^32 / SLOT_DIV), an under-estimate of the quotient fixed by one step
  localparam logic [RW-1:0]    SLOT_RECIP = RW'((64'd1 << 32) / SLOT_DIV_L);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_WARM_RED,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DRAW_RED,
    ST_DRAW_OUT
  } state_t;

  state_t state;

  gen_t first_gen;
  gen_t second_gen;
  gen_t last_output;
  prod_t prod1;
  prod_t prod2;
  fold_t fold1;
  fold_t fold2;
  logic [CNT_W-1:0] cnt;
  logic [QW-1:0] slot_q0;
  logic [IDX_W-1:0] slot_q;
  logic [TABLE_SIZE-1:0] entry_valid;

  // shuffle table storage
  gen_t table_mem [TABLE_SIZE];
  gen_t rd_data;
  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  gen_t mem_wdata;

  gen_t red1;
  gen_t red2;
  gen_t seed_eff;
  logic out_free;
  logic [32+QW-1:0] slot_prod;
  logic [GEN_W+QW-1:0] q_times_div;
  logic [GEN_W+QW-1:0] slot_rem;
  logic [QW-1:0] q_fixed;
  logic [QW-1:0] q_clamped;
  gen_t entry;
  logic [GEN_W:0] out_sum;
  gen_t out_value;

  assign in_stall = rst || (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign seed_eff = (seed_value == '0) ? GEN1_RESET : seed_value;

  assign red1 = mod_fix(fold1, MOD1);
  assign red2 = mod_fix(fold2, MOD2);

  // slot = last_output / SLOT_DIV: reciprocal estimate, then a single correction
  assign slot_prod   = (32 + QW)'(last_output) * (32 + QW)'(SLOT_RECIP);
  assign q_times_div = (GEN_W + QW)'(slot_q0) * (GEN_W + QW)'(SLOT_DIV);
  assign slot_rem    = (GEN_W + QW)'(last_output) - q_times_div;
  assign q_fixed     = (slot_rem >= (GEN_W + QW)'(SLOT_DIV)) ? slot_q0 + 1'b1 : slot_q0;
  assign q_clamped   = (q_fixed >= QW'(TABLE_SIZE)) ? QW'(TABLE_SIZE - 1) : q_fixed;

  // entries never written read as zero
  assign entry     = entry_valid[slot_q] ? rd_data : '0;
  assign out_sum   = {1'b0, entry} + ((entry > second_gen) ? '0 : {1'b0, OUT_MAX})
                     - {1'b0, second_gen};
  assign out_value = out_sum[GEN_W-1:0];

  // table write port: warm-up fill or the slot update of a draw
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = first_gen;
    if (state == ST_WARM_RED && cnt < CNT_W'(TABLE_SIZE)) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[IDX_W-1:0];
      mem_wdata = red1;
    end else if (state == ST_DRAW_OUT && out_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      first_gen    <= GEN1_RESET;
      second_gen   <= GEN2_RESET;
      last_output  <= '0;
      entry_valid  <= '0;
    end else begin
      // a finishing draw reloads the output register in the same cycle
      if (out_valid && !out_stall && state != ST_DRAW_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (mode) begin
              first_gen  <= seed_eff;
              second_gen <= seed_eff;
              cnt        <= CNT_W'(TABLE_SIZE + 7);
              state      <= ST_WARM_MUL;
            end else begin
              state <= ST_DRAW_MUL;
            end
          end
        end
        ST_WARM_MUL: begin
          prod1 <= first_gen * MUL1;
          state <= ST_WARM_FOLD;
        end
        ST_WARM_FOLD: begin
          fold1 <= mod_fold(prod1, FOLD1);
          state <= ST_WARM_RED;
        end
        ST_WARM_RED: begin
          first_gen <= red1;
          if (cnt < CNT_W'(TABLE_SIZE)) begin
            entry_valid[cnt[IDX_W-1:0]] <= 1'b1;
          end
          if (cnt == '0) begin
            last_output <= red1;
            state       <= ST_DRAW_MUL;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= ST_WARM_MUL;
          end
        end
        ST_DRAW_MUL: begin
          prod1   <= first_gen * MUL1;
          prod2   <= second_gen * MUL2;
          slot_q0 <= slot_prod[32 +: QW];
          state   <= ST_DRAW_FOLD;
        end
        ST_DRAW_FOLD: begin
          fold1  <= mod_fold(prod1, FOLD1);
          fold2  <= mod_fold(prod2, FOLD2);
          slot_q <= q_clamped[IDX_W-1:0];
          state  <= ST_DRAW_RED;
        end
        ST_DRAW_RED: begin
          // table read of slot_q is in flight this cycle
          first_gen  <= red1;
          second_gen <= red2;
          state      <= ST_DRAW_OUT;
        end
        ST_DRAW_OUT: begin
          if (out_free) begin
            entry_valid[slot_q] <= 1'b1;
            last_output         <= out_value;
            random_value        <= out_value;
            out_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // every delivered number lies in 1..OUT_MAX
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (random_value != '0) && (random_value <= OUT_MAX))
    else $error("random_value out of range");

  // first generator is always fully reduced when a draw starts
  a_gen1_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_MUL) |-> (first_gen < MOD1))
    else $error("first generator not reduced at draw start");

  // the corrected quotient always names a real table slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_FOLD) |=> (slot_q < TABLE_SIZE))
    else $error("shuffle slot beyond table");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the combined congruential shuffle generator
module testbench;
  import clsr_pkg::*;

  localparam int SLOTS = 32;
  // divisor that maps the previous draw onto a table slot
  localparam gen_t SLOT_SPAN = gen_t'(1 + OUT_MAX / SLOTS);
  // hard limit on the run, with ample room for reseeds and long stalls
  localparam int CYCLE_LIMIT = 500000;
  // extra cycles after the drain, so a straggling output would still be seen
  localparam int TAIL_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [30:0] seed_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] random_value;

  // idle and stall rates in percent, changed per traffic phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // predictor state: both generators, previous draw and the shuffle table
  gen_t mcg1;
  gen_t mcg2;
  gen_t prev_draw;
  gen_t shuffle_slots [SLOTS];
  // draws predicted at input accept, waiting for their output transaction
  gen_t pending_draws [$];
  gen_t expected_draw;

  combined_lcg_shuffle_rng #(
    .TABLE_SIZE(SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_value(random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact modular product, done wide so nothing is lost
  function automatic gen_t mcg_advance(input gen_t value, input logic [15:0] mul,
                                       input gen_t modulus);
    logic [63:0] prod;
    prod = 64'(value) * 64'(mul);
    return gen_t'(prod % 64'(modulus));
  endfunction

  function automatic void model_reset();
    mcg1 = GEN1_RESET;
    mcg2 = GEN2_RESET;
    prev_draw = '0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
  endfunction

  // seed is loaded unreduced; zero counts as one; 8 extra warm-up steps before filling
  function automatic void model_reseed(input gen_t seed);
    int i;
    mcg1 = (seed == '0) ? gen_t'(1) : seed;
    mcg2 = mcg1;
    for (i = SLOTS + 7; i >= 0; i--) begin
      mcg1 = mcg_advance(mcg1, MUL1, MOD1);
      if (i < SLOTS) shuffle_slots[i] = mcg1;
    end
    prev_draw = shuffle_slots[0];
  endfunction

  function automatic gen_t predict_draw(input logic req_mode, input gen_t req_seed);
    int unsigned slot;
    longint diff;
    if (req_mode) model_reseed(req_seed);
    mcg1 = mcg_advance(mcg1, MUL1, MOD1);
    mcg2 = mcg_advance(mcg2, MUL2, MOD2);
    slot = prev_draw / SLOT_SPAN;
    if (slot >= SLOTS) slot = SLOTS - 1;
    diff = longint'(shuffle_slots[slot]) - longint'(mcg2);
    shuffle_slots[slot] = mcg1;
    // wrap back into 1..OUT_MAX
    if (diff < 1) diff += longint'(OUT_MAX);
    prev_draw = gen_t'(diff);
    return prev_draw;
  endfunction

  // mostly full-range seeds, with the corner seeds mixed in now and then
  function automatic gen_t pick_seed();
    case ($urandom_range(15))
      0:       return '0;
      1:       return MOD1;
      2:       return MOD2;
      3:       return '1;
      4:       return gen_t'($urandom_range(255));
      default: return gen_t'($urandom());
    endcase
  endfunction

  // one input transaction: optional idle gap, then hold until accepted
  task automatic send_request(input logic req_mode, input gen_t req_seed);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= req_mode;
    seed_value <= req_seed;
    @(posedge clk);
    // in_stall read here is the value the dut saw at this edge
    while (in_stall) @(posedge clk);
    pending_draws.push_back(predict_draw(req_mode, req_seed));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // roughly one reseed in eight, the rest plain draws with junk seed bits
    repeat (count) send_request($urandom_range(7) == 0, pick_seed());
  endtask

  // draws straight out of reset use the reset generators and an all-zero table
  task automatic test_unseeded_draws();
    send_request(1'b0, '0);
    send_request(1'b0, '1);
    send_request(1'b0, gen_t'($urandom()));
  endtask

  // zero seed, smallest seed, the seed just below MOD1, seeds at and above both moduli
  task automatic test_seed_corners();
    gen_t corners [6];
    corners = '{31'd0, 31'd1, MOD1 - 31'd1, MOD1, MOD2, 31'h7fffffff};
    foreach (corners[i]) begin
      send_request(1'b1, corners[i]);
      send_request(1'b0, '0);
      send_request(1'b0, '1);
    end
  endtask

  // sender holds off until every outstanding draw has come back, then resumes
  task automatic test_drain_pause();
    run_phase(25, 0, 79);
    wait_for_drain();
    run_phase(25, 0, 0);
  endtask

  task automatic test_random_traffic();
    run_phase(140, 0, 0);
    run_phase(140, 79, 0);
    run_phase(140, 0, 79);
    run_phase(140, 9, 9);
    run_phase(140, 0, 0);
  endtask

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $error("random_value: expected nothing, actual %0d", random_value);
        fail_count++;
      end else begin
        expected_draw = pending_draws.pop_front();
        if (random_value !== expected_draw) begin
          $error("random_value: expected %0d, actual %0d", expected_draw, random_value);
          fail_count++;
        end
      end
    end
  end

  // hard stop in case the dut hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_unseeded_draws();
    test_seed_corners();
    test_drain_pause();
    test_random_traffic();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_draws.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
